FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the WELL512 RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: src/well512_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// well512_pkg
// Shared types and constants for the 64-bit WELL512 generator.
// ----------------------------------------------------------------------------
package well512_pkg;

	localparam int POOL_DEPTH = 16;
	localparam int IDX_W      = 4;
	localparam int WORD_W     = 64;

	// pool offsets relative to the current position
	localparam logic [IDX_W-1:0] TAP_X0   = 4'd0;
	localparam logic [IDX_W-1:0] TAP_X9   = 4'd9;
	localparam logic [IDX_W-1:0] TAP_X13  = 4'd13;
	localparam logic [IDX_W-1:0] TAP_PREV = 4'd15;

	localparam logic [WORD_W-1:0] TEMPER_MASK = 64'h0000_0000_DA44_2D24;

	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_GEN  = 1'b1
	} cmd_t;

	// pool words read by one generate
	typedef struct packed {
		logic [WORD_W-1:0] x0;
		logic [WORD_W-1:0] x13;
		logic [WORD_W-1:0] x9;
		logic [WORD_W-1:0] prev;
	} taps_t;

	// pool update request
	typedef struct packed {
		logic              seed_en;
		logic              gen_en;
		logic [IDX_W-1:0]  slot;
		logic [WORD_W-1:0] seed_word;
		logic [WORD_W-1:0] fresh;
		logic [WORD_W-1:0] result;
	} pool_upd_t;

endpackage
`default_nettype wire

FILE: src/well512_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// well512_mix
// Combinational WELL512 mixing: new pool word and tempered result.
// ----------------------------------------------------------------------------
module well512_mix (
	input  well512_pkg::taps_t                   taps,
	output logic [well512_pkg::WORD_W-1:0]       fresh,
	output logic [well512_pkg::WORD_W-1:0]       result
);

	logic [well512_pkg::WORD_W-1:0] mix1;
	logic [well512_pkg::WORD_W-1:0] mix2;
	logic [well512_pkg::WORD_W-1:0] temper;

	always_comb begin
		mix1   = taps.x0 ^ taps.x13 ^ (taps.x0 << 16) ^ (taps.x13 << 15);
		mix2   = taps.x9 ^ (taps.x9 >> 11);
		fresh  = mix1 ^ mix2;
		temper = fresh ^ ((fresh << 5) & well512_pkg::TEMPER_MASK);
		result = taps.prev ^ mix1 ^ temper ^ (taps.prev << 2) ^ (mix1 << 18)
			^ (mix2 << 28);
	end

endmodule
`default_nettype wire

FILE: src/well512_pool.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// well512_pool
// Sixteen-word pool kept rotated so the current position sits at entry 0.
// ----------------------------------------------------------------------------
module well512_pool (
	input  wire                     clk,
	input  wire                     arst_n,
	input  well512_pkg::pool_upd_t  upd,
	output well512_pkg::taps_t      taps
);

	logic [well512_pkg::WORD_W-1:0] rot_q [well512_pkg::POOL_DEPTH];
	logic [well512_pkg::IDX_W-1:0]  pos_q;
	logic [well512_pkg::IDX_W-1:0]  seed_idx;

	// absolute slot -> rotated entry
	assign seed_idx = upd.slot - pos_q;

	assign taps.x0   = rot_q[well512_pkg::TAP_X0];
	assign taps.x13  = rot_q[well512_pkg::TAP_X13];
	assign taps.x9   = rot_q[well512_pkg::TAP_X9];
	assign taps.prev = rot_q[well512_pkg::TAP_PREV];

	// generate: old pos gets fresh, pos-1 gets result, window slides down by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < well512_pkg::POOL_DEPTH; i++) begin
				rot_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (upd.gen_en) begin
			rot_q[0] <= upd.result;
			rot_q[1] <= upd.fresh;
			for (int i = 2; i < well512_pkg::POOL_DEPTH; i++) begin
				rot_q[i] <= rot_q[i-1];
			end
			pos_q <= pos_q - 1'b1;
		end else if (upd.seed_en) begin
			rot_q[seed_idx] <= upd.seed_word;
		end
	end

	`ASSERT_NEXT(a_pos_step, clk, arst_n, upd.gen_en, pos_q == $past(pos_q) - 1'b1)
	`ASSERT_NEXT(a_gen_result_at_head, clk, arst_n, upd.gen_en,
		rot_q[0] == $past(upd.result) && rot_q[1] == $past(upd.fresh))
	`ASSERT_SAME(a_one_update, clk, arst_n, 1'b1, !(upd.gen_en && upd.seed_en))

endmodule
`default_nettype wire

FILE: src/well512_random_generator_64bit_top.sv
// A generate goes through the input register stage, then the result register.
// Throughput: one transaction per cycle, seed or generate, limited by the pool update
//   (rotating 16-word register file, XOR/shift mix); generates wait on a stalled output.
// Reset: arst_n clears the pool to zero, position to zero and both valid stages.
// The pool must be seeded before output is non-zero.
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// well512_random_generator_64bit_top
// 64-bit WELL512 generator: seed transactions load pool words, generate
// transactions return one pseudo-random word each.
// ----------------------------------------------------------------------------
module well512_random_generator_64bit_top (
	input  wire                              clk,
	input  wire                              arst_n,
	// input channel
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              command,
	input  wire  [well512_pkg::IDX_W-1:0]    seed_slot,
	input  wire  [well512_pkg::WORD_W-1:0]   seed_word,
	// output channel
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [well512_pkg::WORD_W-1:0]   random_word
);

	// input register stage
	logic                            valid_s1;
	well512_pkg::cmd_t               cmd_s1;
	logic [well512_pkg::IDX_W-1:0]   slot_s1;
	logic [well512_pkg::WORD_W-1:0]  word_s1;

	// result register
	logic                            out_valid_q;
	logic [well512_pkg::WORD_W-1:0]  random_word_q;

	logic                            out_free;
	logic                            go_s1;
	logic                            gen_go;
	well512_pkg::taps_t              taps;
	well512_pkg::pool_upd_t          upd;
	logic [well512_pkg::WORD_W-1:0]  fresh;
	logic [well512_pkg::WORD_W-1:0]  result;

	// Result register is empty or is taken this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// A seed transaction never needs the result register; a generate does.
	assign go_s1  = valid_s1 && ((cmd_s1 == well512_pkg::CMD_SEED) || out_free);
	assign gen_go = go_s1 && (cmd_s1 == well512_pkg::CMD_GEN);

	// Input stage accepts whenever it is empty or moving on.
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= well512_pkg::cmd_t'(command);
			slot_s1 <= seed_slot;
			word_s1 <= seed_word;
		end
	end

	// Pool update request from the item in the input stage.
	always_comb begin
		upd.seed_en   = go_s1 && (cmd_s1 == well512_pkg::CMD_SEED);
		upd.gen_en    = gen_go;
		upd.slot      = slot_s1;
		upd.seed_word = word_s1;
		upd.fresh     = fresh;
		upd.result    = result;
	end

	well512_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.taps   (taps)
	);

	well512_mix u_mix (
		.taps   (taps),
		.fresh  (fresh),
		.result (result)
	);

	// Result register: loads on a generate, drains when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen_go) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_go) begin
			random_word_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	`ASSERT_NEXT(a_seed_no_result, clk, arst_n,
		valid_s1 && (cmd_s1 == well512_pkg::CMD_SEED) && !(out_valid_q && out_stall),
		!out_valid_q)
	`ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall,
		valid_s1 && (cmd_s1 == well512_pkg::CMD_GEN) && out_valid_q && out_stall)
	`ASSERT_NEXT(a_gen_loads_result, clk, arst_n, gen_go,
		out_valid_q && (random_word_q == $past(result)))

endmodule
`default_nettype wire
